/* rtl/es2c_pkg.sv */
// ----------------------------------------------------------------------------
// es2c_pkg - shared types and constants for the epoch-to-calendar converter
// constants, request structs and the month length function
// ----------------------------------------------------------------------------
package es2c_pkg;

  localparam int EPOCH_W  = 32;   // input seconds count
  localparam int DIVD_W   = 32;   // serial divider dividend / quotient register
  localparam int DSR_W    = 16;   // serial divider divisor and remainder
  localparam int CNT_W    = 6;    // serial divider step count
  localparam int YEAR_W   = 11;
  localparam int MON_W    = 4;
  localparam int DOM_W    = 5;
  localparam int DOY_W    = 9;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int YHRS_W   = 14;   // hours within one year

  localparam logic [DSR_W-1:0]  SEC_PER_MIN     = 16'd60;
  localparam logic [DSR_W-1:0]  HOURS_PER_BLOCK = 16'd35064;  // 1461 days
  localparam logic [DSR_W-1:0]  HOURS_PER_DAY   = 16'd24;
  localparam logic [YHRS_W-1:0] HOURS_COMMON_YR = 14'd8760;
  localparam logic [YHRS_W-1:0] HOURS_LEAP_YR   = 14'd8784;
  localparam logic [YEAR_W-1:0] BASE_YEAR       = 11'd1970;
  localparam logic [DOY_W-1:0]  LEAP_DAY_OF_YR  = 9'd60;
  localparam logic [DOM_W-1:0]  LEAP_DAY_DOM    = 5'd29;

  localparam logic [MON_W-1:0]  MONTH_JAN = 4'd1;
  localparam logic [MON_W-1:0]  MONTH_FEB = 4'd2;
  localparam logic [MON_W-1:0]  MONTH_DEC = 4'd12;

  // significant dividend bits of each division pass
  localparam logic [CNT_W-1:0]  BITS_SECS  = 6'd31;
  localparam logic [CNT_W-1:0]  BITS_MINS  = 6'd26;
  localparam logic [CNT_W-1:0]  BITS_HOURS = 6'd20;
  localparam logic [CNT_W-1:0]  BITS_YHRS  = 6'd14;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;   // left aligned
    logic [DSR_W-1:0]  divisor;
    logic [CNT_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic             leap;
    logic [DOY_W-1:0] doy;         // day of year, from one
  } mw_req_t;

  function automatic logic [DOM_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DOM_W-1:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/es2c_sdiv.sv */
// ----------------------------------------------------------------------------
// es2c_sdiv - bit-serial restoring divider
// one quotient bit per cycle, quotient shifts into the dividend register
// ----------------------------------------------------------------------------
module es2c_sdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  es2c_pkg::div_req_t            req,
  output logic                          done,
  output logic [es2c_pkg::DIVD_W-1:0]   quo,
  output logic [es2c_pkg::DSR_W-1:0]    rem
);
  import es2c_pkg::*;

  logic [DIVD_W-1:0] a_r, a_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              ge;

  // trial subtract of the next partial remainder
  assign trial = {rem_r, a_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt   = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
      cnt_nxt = req.nbits;
    end else if (cnt_r != '0) begin
      a_nxt    = {a_r[DIVD_W-2:0], ge};
      rem_nxt  = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quo  = a_r;
  assign rem  = rem_r;

endmodule

/* rtl/es2c_mwalk.sv */
// ----------------------------------------------------------------------------
// es2c_mwalk - month walker
// splits a day of year into month and day of month, one month per cycle
// ----------------------------------------------------------------------------
module es2c_mwalk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  es2c_pkg::mw_req_t            req,
  output logic                         done,
  output logic [es2c_pkg::MON_W-1:0]   month,
  output logic [es2c_pkg::DOM_W-1:0]   dom
);
  import es2c_pkg::*;

  logic              run_r, run_nxt;
  logic              fin_r, fin_nxt;
  logic [MON_W-1:0]  mon_r, mon_nxt;
  logic [DOY_W-1:0]  day_r, day_nxt;
  logic [DOY_W-1:0]  len;
  logic              stop;

  assign len  = {{(DOY_W-DOM_W){1'b0}}, month_len(mon_r)};
  assign stop = fin_r || (mon_r == MONTH_DEC) || (len >= day_r);

  always_comb begin
    run_nxt = run_r;
    fin_nxt = fin_r;
    mon_nxt = mon_r;
    day_nxt = day_r;
    if (req.start) begin
      run_nxt = 1'b1;
      fin_nxt = 1'b0;
      mon_nxt = MONTH_JAN;
      day_nxt = req.doy;
      if (req.leap && (req.doy == LEAP_DAY_OF_YR)) begin
        // february 29 is final right away
        fin_nxt = 1'b1;
        mon_nxt = MONTH_FEB;
        day_nxt = {{(DOY_W-DOM_W){1'b0}}, LEAP_DAY_DOM};
      end else if (req.leap && (req.doy > LEAP_DAY_OF_YR)) begin
        day_nxt = req.doy - 1'b1;
      end
    end else if (run_r) begin
      if (stop) begin
        run_nxt = 1'b0;
      end else begin
        day_nxt = day_r - len;
        mon_nxt = mon_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mon_r <= mon_nxt;
    day_r <= day_nxt;
  end

  assign done  = run_r && stop;
  assign month = mon_r;
  assign dom   = day_r[DOM_W-1:0];

endmodule

/* rtl/epoch_seconds_to_calendar_core.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core - seconds since 1970 to calendar date/time
// throughput: one conversion at a time; the input stalls from a transfer until
//   the result enters the output register, which waits while the output stalls;
//   conversion time is set by the bit-serial divider (31 + 26 + 20 + 14
//   quotient bits) plus up to 3 year and 11 month steps
// reset: synchronous active low, clears the sequencer and the result valid
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [es2c_pkg::EPOCH_W-1:0] in_epoch_seconds,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [es2c_pkg::SEC_W-1:0]     out_second,
  output logic [es2c_pkg::MIN_W-1:0]     out_minute,
  output logic [es2c_pkg::HOUR_W-1:0]    out_hour,
  output logic [es2c_pkg::DOM_W-1:0]     out_day_of_month,
  output logic [es2c_pkg::MON_W-1:0]     out_month,
  output logic [es2c_pkg::YEAR_W-1:0]    out_year
);
  import es2c_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an input transfer
  localparam logic [2:0] ST_SECS = 3'd1;  // seconds / 60
  localparam logic [2:0] ST_MINS = 3'd2;  // minutes / 60
  localparam logic [2:0] ST_BLK  = 3'd3;  // hours / four-year block
  localparam logic [2:0] ST_YEAR = 3'd4;  // walk years inside the block
  localparam logic [2:0] ST_DAY  = 3'd5;  // hours of year / 24
  localparam logic [2:0] ST_MON  = 3'd6;  // month walk
  localparam logic [2:0] ST_DONE = 3'd7;  // hand over to output register

  logic [2:0]        state_r, state_nxt;
  logic              accept;

  // working values
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [YEAR_W-1:0] yr_r, yr_nxt;
  logic [DSR_W-1:0]  hrs_r, hrs_nxt;       // hours left within block / year
  logic [MON_W-1:0]  mon_r, mon_nxt;
  logic [DOM_W-1:0]  dom_r, dom_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [SEC_W-1:0]  out_sec_r;
  logic [MIN_W-1:0]  out_min_r;
  logic [HOUR_W-1:0] out_hour_r;
  logic [DOM_W-1:0]  out_dom_r;
  logic [MON_W-1:0]  out_mon_r;
  logic [YEAR_W-1:0] out_yr_r;
  logic              out_load;

  // shared divider and month walker
  div_req_t          div_req;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;
  logic [DSR_W-1:0]  div_rem;
  mw_req_t           mw_req;
  logic              mw_done;
  logic [MON_W-1:0]  mw_month;
  logic [DOM_W-1:0]  mw_dom;

  logic [DIVD_W-1:0] clamped;
  logic              leap;
  logic [YHRS_W-1:0] year_hrs;
  logic              year_fits;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  // negative counts become zero
  assign clamped  = in_epoch_seconds[EPOCH_W-1] ? '0 : DIVD_W'(in_epoch_seconds);

  assign leap      = (yr_r[1:0] == 2'b00);
  assign year_hrs  = leap ? HOURS_LEAP_YR : HOURS_COMMON_YR;
  assign year_fits = (hrs_r < {{(DSR_W-YHRS_W){1'b0}}, year_hrs});

  // output register frees when empty or when its transfer happens now
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    yr_nxt    = yr_r;
    hrs_nxt   = hrs_r;
    mon_nxt   = mon_r;
    dom_nxt   = dom_r;

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = SEC_PER_MIN;
    div_req.nbits    = BITS_SECS;

    mw_req.start = 1'b0;
    mw_req.leap  = leap;
    mw_req.doy   = div_quo[DOY_W-1:0] + 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // dividend left aligned to its 31 significant bits
          div_req.start    = 1'b1;
          div_req.dividend = {clamped[DIVD_W-2:0], 1'b0};
          div_req.divisor  = SEC_PER_MIN;
          div_req.nbits    = BITS_SECS;
          state_nxt        = ST_SECS;
        end
      end
      ST_SECS: begin
        if (div_done) begin
          sec_nxt          = div_rem[SEC_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = {div_quo[25:0], 6'b0};
          div_req.divisor  = SEC_PER_MIN;
          div_req.nbits    = BITS_MINS;
          state_nxt        = ST_MINS;
        end
      end
      ST_MINS: begin
        if (div_done) begin
          min_nxt          = div_rem[MIN_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = {div_quo[19:0], 12'b0};
          div_req.divisor  = HOURS_PER_BLOCK;
          div_req.nbits    = BITS_HOURS;
          state_nxt        = ST_BLK;
        end
      end
      ST_BLK: begin
        if (div_done) begin
          // four years per block
          yr_nxt    = BASE_YEAR + {4'b0, div_quo[4:0], 2'b00};
          hrs_nxt   = div_rem;
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (year_fits) begin
          div_req.start    = 1'b1;
          div_req.dividend = {hrs_r[YHRS_W-1:0], 18'b0};
          div_req.divisor  = HOURS_PER_DAY;
          div_req.nbits    = BITS_YHRS;
          state_nxt        = ST_DAY;
        end else begin
          hrs_nxt = hrs_r - {{(DSR_W-YHRS_W){1'b0}}, year_hrs};
          yr_nxt  = yr_r + 1'b1;
        end
      end
      ST_DAY: begin
        if (div_done) begin
          hour_nxt     = div_rem[HOUR_W-1:0];
          mw_req.start = 1'b1;
          state_nxt    = ST_MON;
        end
      end
      ST_MON: begin
        if (mw_done) begin
          mon_nxt   = mw_month;
          dom_nxt   = mw_dom;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid holds until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    yr_r   <= yr_nxt;
    hrs_r  <= hrs_nxt;
    mon_r  <= mon_nxt;
    dom_r  <= dom_nxt;
    if (out_load) begin
      out_sec_r  <= sec_r;
      out_min_r  <= min_r;
      out_hour_r <= hour_r;
      out_dom_r  <= dom_r;
      out_mon_r  <= mon_r;
      out_yr_r   <= yr_r;
    end
  end

  es2c_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  es2c_mwalk u_mwalk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mw_req),
    .done  (mw_done),
    .month (mw_month),
    .dom   (mw_dom)
  );

  assign out_valid        = out_valid_r;
  assign out_second       = out_sec_r;
  assign out_minute       = out_min_r;
  assign out_hour         = out_hour_r;
  assign out_day_of_month = out_dom_r;
  assign out_month        = out_mon_r;
  assign out_year         = out_yr_r;

endmodule

/* bench/tb_epoch_seconds_to_calendar_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_core - self-checking bench for the epoch converter
// drives signed second counts through the valid/stall input channel and checks
// every calendar result, in order, against typed-in dates or an in-bench calendar predictor
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_core;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 150;    // a bit more than the converter latency
  localparam int HOLD_CYCLES  = 600;    // long receiver hold-off
  localparam int PHASE_ITEMS  = 180;
  localparam int NUM_PHASES   = 3;
  localparam int NUM_ROWS     = 22;

  // calendar constants; block and year lengths are in hours, as used after the minute/second split
  localparam int unsigned EPOCH_YEAR      = 1970;
  localparam int unsigned HRS_PER_QUAD    = 1461 * 24;
  localparam int unsigned HRS_COMMON_YEAR = 365 * 24;
  localparam int unsigned LEAP_DAY_INDEX  = 60;
  localparam int unsigned SECS_PER_DAY    = 86400;
  localparam int unsigned LAST_FULL_DAY   = 24855;

  typedef struct packed {
    logic [es2c_pkg::SEC_W-1:0]  second;
    logic [es2c_pkg::MIN_W-1:0]  minute;
    logic [es2c_pkg::HOUR_W-1:0] hour;
    logic [es2c_pkg::DOM_W-1:0]  day_of_month;
    logic [es2c_pkg::MON_W-1:0]  month;
    logic [es2c_pkg::YEAR_W-1:0] year;
  } cal_t;

  // directed stimulus row: literal set means the date is typed in below
  typedef struct packed {
    logic signed [31:0] secs;
    logic               literal;
    cal_t               want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [es2c_pkg::EPOCH_W-1:0] in_epoch_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [es2c_pkg::SEC_W-1:0]  out_second;
  logic [es2c_pkg::MIN_W-1:0]  out_minute;
  logic [es2c_pkg::HOUR_W-1:0] out_hour;
  logic [es2c_pkg::DOM_W-1:0]  out_day_of_month;
  logic [es2c_pkg::MON_W-1:0]  out_month;
  logic [es2c_pkg::YEAR_W-1:0] out_year;

  cal_t pending_dates[$];         // predicted dates, oldest first
  int   error_count = 0;
  int   cycle_count = 0;
  int   sender_idle_pct = 6;
  int   receiver_stall_pct = 55;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;

  int unsigned days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // directed table: extremes, clamping, leap day and year/month rollovers
  row_t directed_rows [NUM_ROWS] = '{
    '{32'sd0,                 1'b1, '{6'd0,  6'd0,  5'd0,  5'd1,  4'd1, 11'd1970}},
    '{-32'sd1,                1'b1, '{6'd0,  6'd0,  5'd0,  5'd1,  4'd1, 11'd1970}},
    '{32'sh80000000,          1'b1, '{6'd0,  6'd0,  5'd0,  5'd1,  4'd1, 11'd1970}},
    '{32'sh7fffffff,          1'b1, '{6'd7,  6'd14, 5'd3,  5'd19, 4'd1, 11'd2038}},
    '{32'sd68169600,          1'b1, '{6'd0,  6'd0,  5'd0,  5'd29, 4'd2, 11'd1972}},
    '{32'sd59,                1'b0, '0},
    '{32'sd60,                1'b0, '0},
    '{32'sd3599,              1'b0, '0},
    '{32'sd86399,             1'b0, '0},
    '{32'sd31535999,          1'b0, '0},  // last second of 1970
    '{32'sd68169599,          1'b0, '0},  // eve of the leap day
    '{32'sd68255999,          1'b0, '0},
    '{32'sd68256000,          1'b0, '0},  // march 1 of a leap year
    '{32'sd94694399,          1'b0, '0},
    '{32'sd94694400,          1'b0, '0},
    '{32'sd951782400,         1'b0, '0},  // century leap day
    '{32'sd978307199,         1'b0, '0},
    '{32'sd1709164800,        1'b0, '0},
    '{32'sd2145916799,        1'b0, '0},  // last second of the last full year
    '{32'sd1431655765,        1'b0, '0},  // alternating bits
    '{32'sd715827882,         1'b0, '0},
    '{32'shffff0000,          1'b0, '0}   // large negative
  };

  epoch_seconds_to_calendar_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // calendar predictor: clamp, split off seconds and minutes, walk four-year
  // blocks of hours, then years, then months with the leap day handled apart
  function automatic cal_t calendar_of(input logic signed [31:0] secs);
    cal_t        c;
    int unsigned t;
    int unsigned yr;
    int unsigned yr_hours;
    int unsigned day;
    int unsigned mon;
    int unsigned guard;
    bit          leap;
    t = secs[31] ? 0 : secs;
    c.second = es2c_pkg::SEC_W'(t % 60);
    t = t / 60;
    c.minute = es2c_pkg::MIN_W'(t % 60);
    t = t / 60;
    yr = EPOCH_YEAR + 4 * (t / HRS_PER_QUAD);
    t = t % HRS_PER_QUAD;
    guard = 0;
    while (guard < 4) begin
      yr_hours = HRS_COMMON_YEAR + (((yr & 3) == 0) ? 24 : 0);
      if (t < yr_hours) break;
      t = t - yr_hours;
      yr = yr + 1;
      guard = guard + 1;
    end
    c.hour = es2c_pkg::HOUR_W'(t % 24);
    day = t / 24 + 1;
    leap = ((yr & 3) == 0);
    if (leap && day == LEAP_DAY_INDEX) begin
      mon = 2;
      day = 29;
    end else begin
      if (leap && day > LEAP_DAY_INDEX) day = day - 1;
      mon = 1;
      while (mon < 12 && days_in_month[mon-1] < day) begin
        day = day - days_in_month[mon-1];
        mon = mon + 1;
      end
    end
    c.day_of_month = es2c_pkg::DOM_W'(day);
    c.month = es2c_pkg::MON_W'(mon);
    c.year = es2c_pkg::YEAR_W'(yr);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // one transfer on the input channel, then maybe a sender gap
  task automatic offer_epoch(input logic signed [31:0] secs, input logic literal,
                             input cal_t want);
    int gap;
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(literal ? want : calendar_of(secs));
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender goes quiet until every predicted date has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // random count: mostly day boundaries, some arbitrary, a few negative
  function automatic logic signed [31:0] random_epoch();
    longint s;
    int unsigned tod;
    case ($urandom_range(9))
      0: s = $signed($urandom);
      1, 2, 3: s = $urandom & 32'h7fffffff;
      default: begin
        case ($urandom_range(3))
          0: tod = 0;
          1: tod = SECS_PER_DAY - 1;
          2: tod = $urandom_range(1, 2);
          default: tod = $urandom_range(SECS_PER_DAY - 1);
        endcase
        s = longint'($urandom_range(LAST_FULL_DAY)) * SECS_PER_DAY + tod;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
      end
    endcase
    return s[31:0];
  endfunction

  // receiver: random stall per cycle, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // result checker: each output transfer against the oldest prediction
  always @(posedge clk) begin
    cal_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with nothing pending, year", int'(out_year), 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_second !== want.second)
          report_mismatch("second", int'(out_second), int'(want.second));
        if (out_minute !== want.minute)
          report_mismatch("minute", int'(out_minute), int'(want.minute));
        if (out_hour !== want.hour)
          report_mismatch("hour", int'(out_hour), int'(want.hour));
        if (out_day_of_month !== want.day_of_month)
          report_mismatch("day_of_month", int'(out_day_of_month),
                          int'(want.day_of_month));
        if (out_month !== want.month)
          report_mismatch("month", int'(out_month), int'(want.month));
        if (out_year !== want.year)
          report_mismatch("year", int'(out_year), int'(want.year));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int row;
    int phase;
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, with the mild sender idling and heavy receiver stalls
    for (row = 0; row < NUM_ROWS; row++)
      offer_epoch(directed_rows[row].secs, directed_rows[row].literal,
                  directed_rows[row].want);
    wait_drained();

    // random phases: sender light / receiver heavy, then swapped, then no random idling but a long hold-off
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct <= 6;
          receiver_stall_pct <= 55;
        end
        1: begin
          sender_idle_pct <= 55;
          receiver_stall_pct <= 6;
        end
        default: begin
          sender_idle_pct <= 0;
          receiver_stall_pct <= 0;
          // receiver holds off while the sender keeps offering transfers
          hold_requests <= hold_requests + 1;
        end
      endcase
      @(posedge clk);
      for (n = 0; n < PHASE_ITEMS; n++)
        offer_epoch(random_epoch(), 1'b0, '0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/es2c_pkg.sv
rtl/es2c_sdiv.sv
rtl/es2c_mwalk.sv
rtl/epoch_seconds_to_calendar_core.sv
bench/tb_epoch_seconds_to_calendar_core.sv
